// File: hdl/gnbm_pkg.sv
// Shared constants, widths and helper functions of the Box-Muller noise generator.
// No dependencies; imported by gnbm_radius, gnbm_angle and gaussian_noise_box_muller.
package gnbm_pkg;

    // Port widths and parameter defaults
    localparam int unsigned IN_W               = 32;
    localparam int unsigned OUT_W              = 16;
    localparam int unsigned UNIFORM_BITS_DEF   = 32;
    localparam int unsigned OUT_FRAC_BITS_DEF  = 12;

    // Logarithm: Q28, integer part is a bit position
    localparam int unsigned LOG_FRAC = 28;
    localparam int unsigned EXP_W    = 5;
    localparam int unsigned LOG_W    = EXP_W + LOG_FRAC;

    // -2 ln u1 in Q28 and its square root
    localparam int unsigned R_W       = 34;
    localparam int unsigned SQ_OP_W   = R_W + LOG_FRAC;
    localparam int unsigned SQ_STAGES = SQ_OP_W / 2;
    localparam int unsigned SQRT_W    = 31;

    // Angle path: Q30 values
    localparam int unsigned Q30_W        = 30;
    localparam int unsigned TRIG_W       = 31;
    localparam int unsigned HORNER_STEPS = 4;

    localparam logic [TRIG_W-1:0] ONE_Q30      = 31'h4000_0000;
    localparam logic [TRIG_W-1:0] HALF_Q30     = 31'h2000_0000;
    localparam logic [TRIG_W-1:0] HALF_PI_Q30  = 31'd1686629713;
    localparam logic [TRIG_W-1:0] LN2X2_Q30    = 31'd1488522236;

    // Pipeline depths (register stages)
    localparam int unsigned RAD_LAT = 1 + LOG_FRAC + 2 + SQ_STAGES;
    localparam int unsigned ANG_LAT = 3 + 3 * HORNER_STEPS + 1;
    localparam int unsigned ANG_DLY = RAD_LAT - ANG_LAT;

    localparam int unsigned DIV_W = 7;
    localparam int unsigned REC_W = 32;

    // Series divisor of Horner step k (cos or sin branch)
    function automatic logic [DIV_W-1:0] horner_div(input int unsigned k, input logic sin_sel);
        logic [DIV_W-1:0] d;
        case (k)
            0: d = sin_sel ? 7'd72 : 7'd56;
            1: d = sin_sel ? 7'd42 : 7'd30;
            2: d = sin_sel ? 7'd20 : 7'd12;
            default: d = sin_sel ? 7'd6 : 7'd2;
        endcase
        return d;
    endfunction

    // floor(2^32 / divisor) for the same step
    function automatic logic [REC_W-1:0] horner_rec(input int unsigned k, input logic sin_sel);
        logic [REC_W-1:0] r;
        case (k)
            0: r = sin_sel ? 32'd59652323  : 32'd76695844;
            1: r = sin_sel ? 32'd102261126 : 32'd143165576;
            2: r = sin_sel ? 32'd214748364 : 32'd357913941;
            default: r = sin_sel ? 32'd715827882 : 32'd2147483648;
        endcase
        return r;
    endfunction

    // Q28 log2 of a nonzero word, for elaboration-time constants
    function automatic logic [LOG_W-1:0] log2_q28(input logic [IN_W-1:0] v);
        logic [EXP_W-1:0] e;
        logic [IN_W-1:0] m;
        logic [2*IN_W-1:0] sq;
        logic [LOG_W-1:0] acc;
        e = '0;
        for (int i = 0; i < IN_W; i++) begin
            if (v[i]) e = EXP_W'(i);
        end
        m = v << (5'd31 - e);
        acc = {e, {LOG_FRAC{1'b0}}};
        for (int i = 1; i <= LOG_FRAC; i++) begin
            sq = (2*IN_W)'(m) * (2*IN_W)'(m);
            if (sq[63]) begin
                m = sq[63:32];
                acc[LOG_FRAC - i] = 1'b1;
            end else begin
                m = sq[62:31];
            end
        end
        return acc;
    endfunction

endpackage

// File: hdl/gnbm_radius.sv
// Radius path: sqrt(-2 ln u1) in Q28 through log2 by repeated squaring and a
// one-bit-per-stage square root. Depends on gnbm_pkg.
module gnbm_radius #(
    parameter int unsigned UNIFORM_BITS = gnbm_pkg::UNIFORM_BITS_DEF
) (
    input  logic                          aclk,
    input  logic                          en,
    input  logic [gnbm_pkg::IN_W-1:0]     radius_word,
    output logic [gnbm_pkg::SQRT_W-1:0]   radius_out
);
    import gnbm_pkg::*;

    localparam logic [IN_W-1:0]  MASK = IN_W'((64'd1 << UNIFORM_BITS) - 64'd1);
    localparam logic [LOG_W-1:0] LMAX = log2_q28(MASK);

    logic [IN_W-1:0]     w1;
    logic [EXP_W-1:0]    e_next;
    logic [IN_W-1:0]     m_next;

    logic [IN_W-1:0]     lm_reg [LOG_FRAC+1];
    logic [LOG_FRAC-1:0] lf_reg [LOG_FRAC+1];
    logic [EXP_W-1:0]    le_reg [LOG_FRAC+1];

    logic [LOG_W-1:0]    lw;
    logic [LOG_W-1:0]    d_next;
    logic [LOG_W-1:0]    d_reg;
    logic [63:0]         r_prod;
    logic [R_W-1:0]      r_reg;

    logic [SQ_OP_W-1:0]  rem_in [SQ_STAGES];
    logic [SQ_OP_W-1:0]  res_in [SQ_STAGES];
    logic [SQ_OP_W-1:0]  sq_rem_reg [SQ_STAGES];
    logic [SQ_OP_W-1:0]  sq_res_reg [SQ_STAGES];

    // Find the leading one and normalize the mantissa to bit 31
    always_comb begin
        w1 = radius_word & MASK;
        e_next = '0;
        for (int i = 0; i < IN_W; i++) begin
            if (w1[i]) e_next = EXP_W'(i);
        end
        m_next = w1 << (5'd31 - e_next);
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            lm_reg[0] <= m_next;
            lf_reg[0] <= '0;
            le_reg[0] <= e_next;
        end
    end

    // One fraction bit per stage: square, renormalize, record overflow
    for (genvar k = 0; k < LOG_FRAC; k++) begin : g_sq
        logic [2*IN_W-1:0]   sq;
        logic [IN_W-1:0]     m_sq_next;
        logic [LOG_FRAC-1:0] f_sq_next;

        always_comb begin
            sq = (2*IN_W)'(lm_reg[k]) * (2*IN_W)'(lm_reg[k]);
            f_sq_next = lf_reg[k];
            if (sq[63]) begin
                m_sq_next = sq[63:32];
                f_sq_next[LOG_FRAC-1-k] = 1'b1;
            end else begin
                m_sq_next = sq[62:31];
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                lm_reg[k+1] <= m_sq_next;
                lf_reg[k+1] <= f_sq_next;
                le_reg[k+1] <= le_reg[k];
            end
        end
    end

    // Distance from log2 of the all-ones word, clamped at zero
    always_comb begin
        lw = {le_reg[LOG_FRAC], lf_reg[LOG_FRAC]};
        d_next = (LMAX > lw) ? LMAX - lw : '0;
        r_prod = 64'(d_reg) * 64'(LN2X2_Q30);
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            d_reg <= d_next;
            r_reg <= r_prod[63:30];
        end
    end

    // Restoring square root, one result bit per stage
    for (genvar k = 0; k < SQ_STAGES; k++) begin : g_sqrt
        localparam logic [SQ_OP_W-1:0] BIT = SQ_OP_W'(1) << (SQ_OP_W - 2 - 2*k);
        logic [SQ_OP_W-1:0] trial;
        logic [SQ_OP_W-1:0] rem_next;
        logic [SQ_OP_W-1:0] res_next;

        if (k == 0) begin : g_first
            assign rem_in[k] = {r_reg, {LOG_FRAC{1'b0}}};
            assign res_in[k] = '0;
        end else begin : g_rest
            assign rem_in[k] = sq_rem_reg[k-1];
            assign res_in[k] = sq_res_reg[k-1];
        end

        always_comb begin
            trial = res_in[k] + BIT;
            if (rem_in[k] >= trial) begin
                rem_next = rem_in[k] - trial;
                res_next = (res_in[k] >> 1) + BIT;
            end else begin
                rem_next = rem_in[k];
                res_next = res_in[k] >> 1;
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                sq_rem_reg[k] <= rem_next;
                sq_res_reg[k] <= res_next;
            end
        end
    end

    assign radius_out = sq_res_reg[SQ_STAGES-1][SQRT_W-1:0];

endmodule

// File: hdl/gnbm_angle.sv
// Angle path: cos(2 pi u2) as a Q30 magnitude and a sign, by quadrant folding
// and a pipelined Horner series. Depends on gnbm_pkg.
module gnbm_angle #(
    parameter int unsigned UNIFORM_BITS = gnbm_pkg::UNIFORM_BITS_DEF
) (
    input  logic                          aclk,
    input  logic                          en,
    input  logic [gnbm_pkg::IN_W-1:0]     angle_word,
    output logic [gnbm_pkg::TRIG_W-1:0]   cos_mag,
    output logic                          cos_neg
);
    import gnbm_pkg::*;

    localparam int unsigned REP = (IN_W + UNIFORM_BITS - 1) / UNIFORM_BITS;

    typedef struct packed {
        logic [Q30_W-1:0] x;
        logic [Q30_W-1:0] t;
        logic             sin_sel;
        logic             neg;
    } side_t;

    logic [UNIFORM_BITS-1:0]     w2;
    logic [REP*UNIFORM_BITS-1:0] rep;
    logic [IN_W-1:0]             phase;
    logic [1:0]                  quad;
    logic [TRIG_W-1:0]           mq;
    logic                        sel_next;
    logic [Q30_W-1:0]            a_next;

    logic [Q30_W-1:0] a_reg;
    logic             sel_reg;
    logic             neg_reg;
    logic [63:0]      x_prod;
    logic [Q30_W-1:0] x_reg;
    logic             sel2_reg;
    logic             neg2_reg;
    logic [63:0]      t_prod;
    side_t            side3_reg;

    side_t             side_in [HORNER_STEPS];
    logic [TRIG_W-1:0] h_in    [HORNER_STEPS];
    side_t             sa_reg  [HORNER_STEPS];
    logic [Q30_W-1:0]  p_reg   [HORNER_STEPS];
    side_t             sb_reg  [HORNER_STEPS];
    logic [Q30_W-1:0]  pb_reg  [HORNER_STEPS];
    logic [Q30_W-1:0]  qe_reg  [HORNER_STEPS];
    side_t             sc_reg  [HORNER_STEPS];
    logic [TRIG_W-1:0] h_reg   [HORNER_STEPS];

    logic [63:0]       f_prod;
    logic [TRIG_W-1:0] c_next;
    logic [TRIG_W-1:0] c_reg;
    logic              cneg_reg;

    // Phase in turns: the word's bit pattern repeated, the all-ones word wraps to zero
    always_comb begin
        w2 = angle_word[UNIFORM_BITS-1:0];
        rep = {REP{w2}};
        phase = (w2 == {UNIFORM_BITS{1'b1}}) ? '0 : rep[REP*UNIFORM_BITS-1 -: IN_W];
        quad = phase[31:30];
        mq = quad[0] ? ONE_Q30 - TRIG_W'(phase[29:0]) : TRIG_W'(phase[29:0]);
        sel_next = (mq > HALF_Q30);
        a_next = sel_next ? Q30_W'(ONE_Q30 - mq) : Q30_W'(mq);
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            a_reg   <= a_next;
            sel_reg <= sel_next;
            neg_reg <= quad[1] ^ quad[0];
        end
    end

    // Scale to radians, then square
    assign x_prod = 64'(a_reg) * 64'(HALF_PI_Q30);
    assign t_prod = 64'(x_reg) * 64'(x_reg);

    always_ff @(posedge aclk) begin
        if (en) begin
            x_reg             <= x_prod[59:30];
            sel2_reg          <= sel_reg;
            neg2_reg          <= neg_reg;
            side3_reg.x       <= x_reg;
            side3_reg.t       <= t_prod[59:30];
            side3_reg.sin_sel <= sel2_reg;
            side3_reg.neg     <= neg2_reg;
        end
    end

    // Horner steps: h = 1 - (t*h)/D, three stages each
    for (genvar k = 0; k < HORNER_STEPS; k++) begin : g_horner
        logic [63:0]       tp_prod;
        logic [63:0]       rc_prod;
        logic [DIV_W-1:0]  dv;
        logic [Q30_W-1:0]  rem;
        logic [Q30_W-1:0]  quo;
        logic [TRIG_W-1:0] h_next;

        if (k == 0) begin : g_first
            assign side_in[k] = side3_reg;
            assign h_in[k]    = ONE_Q30;
        end else begin : g_rest
            assign side_in[k] = sc_reg[k-1];
            assign h_in[k]    = h_reg[k-1];
        end

        always_comb begin
            tp_prod = 64'(side_in[k].t) * 64'(h_in[k]);
            rc_prod = 64'(p_reg[k]) * 64'(horner_rec(k, sa_reg[k].sin_sel));
            dv      = horner_div(k, sb_reg[k].sin_sel);
            rem     = pb_reg[k] - Q30_W'(qe_reg[k] * Q30_W'(dv));
            quo     = qe_reg[k] + Q30_W'(rem >= Q30_W'(dv));
            h_next  = ONE_Q30 - TRIG_W'(quo);
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                p_reg[k]  <= tp_prod[59:30];
                sa_reg[k] <= side_in[k];
                pb_reg[k] <= p_reg[k];
                qe_reg[k] <= rc_prod[61:32];
                sb_reg[k] <= sa_reg[k];
                h_reg[k]  <= h_next;
                sc_reg[k] <= sb_reg[k];
            end
        end
    end

    // Sine branch takes one more multiply by x
    always_comb begin
        f_prod = 64'(sc_reg[HORNER_STEPS-1].x) * 64'(h_reg[HORNER_STEPS-1]);
        c_next = sc_reg[HORNER_STEPS-1].sin_sel ? TRIG_W'(f_prod[59:30])
                                                : h_reg[HORNER_STEPS-1];
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            c_reg    <= c_next;
            cneg_reg <= sc_reg[HORNER_STEPS-1].neg;
        end
    end

    assign cos_mag = c_reg;
    assign cos_neg = cneg_reg;

endmodule

// File: hdl/gaussian_noise_box_muller.sv
// Top level of the Box-Muller Gaussian noise generator.
// Depends on gnbm_pkg, gnbm_radius and gnbm_angle.
//
// Takes one pair of uniform words per clock and returns one Gaussian sample,
// sqrt(-2 ln u1) * cos(2 pi u2), in signed fixed point with OUT_FRAC_BITS
// fraction bits, saturated to 16 bits. A pair whose radius word is zero (within
// the low UNIFORM_BITS bits) is accepted and produces no sample. The pipeline
// sustains one item per clock; each sample passes 1 normalize stage, 28 log2
// squaring stages, 2 stages for the log scaling, 31 square-root stages, one
// product stage and the output register. The whole pipeline holds while a
// finished sample waits on m_ready.
module gaussian_noise_box_muller #(
    parameter int unsigned UNIFORM_BITS  = gnbm_pkg::UNIFORM_BITS_DEF,
    parameter int unsigned OUT_FRAC_BITS = gnbm_pkg::OUT_FRAC_BITS_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic [gnbm_pkg::IN_W-1:0]         s_uniform_radius_word,
    input  logic [gnbm_pkg::IN_W-1:0]         s_uniform_angle_word,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic signed [gnbm_pkg::OUT_W-1:0] m_noise_sample
);
    import gnbm_pkg::*;

    localparam int unsigned SHIFT   = 58 - OUT_FRAC_BITS;
    localparam int unsigned SUM_W   = 63;
    localparam int unsigned PROD_W  = 62;
    localparam logic [SUM_W-1:0] RND     = SUM_W'(1) << (SHIFT - 1);
    localparam logic [SUM_W-1:0] SAT_POS = SUM_W'((1 << (OUT_W - 1)) - 1);
    localparam logic [SUM_W-1:0] SAT_NEG = SUM_W'(1 << (OUT_W - 1));

    logic                 en;
    logic                 zero_word;
    logic [RAD_LAT-1:0]   vld_reg;
    logic [RAD_LAT-1:0]   vld_next;

    logic [SQRT_W-1:0]    radius;
    logic [TRIG_W-1:0]    cos_mag;
    logic                 cos_neg;

    logic [TRIG_W-1:0]    dly_c_reg   [ANG_DLY];
    logic                 dly_neg_reg [ANG_DLY];

    logic [63:0]          prod_full;
    logic [PROD_W-1:0]    prod_reg;
    logic                 prod_neg_reg;
    logic                 prod_vld_reg;

    logic [SUM_W-1:0]     sum;
    logic [SUM_W-1:0]     mag;
    logic [SUM_W-1:0]     sat;
    logic [OUT_W-1:0]     sample_next;
    logic [OUT_W-1:0]     sample_reg;
    logic                 m_valid_reg;

    // Advance everything when the output register is free or being drained
    assign en      = !m_valid_reg || m_ready;
    assign s_ready = en;

    assign zero_word = (s_uniform_radius_word[UNIFORM_BITS-1:0] == '0);
    assign vld_next  = {vld_reg[RAD_LAT-2:0], s_valid && !zero_word};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg      <= '0;
            prod_vld_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else if (en) begin
            vld_reg      <= vld_next;
            prod_vld_reg <= vld_reg[RAD_LAT-1];
            m_valid_reg  <= prod_vld_reg;
        end
    end

    gnbm_radius #(
        .UNIFORM_BITS (UNIFORM_BITS)
    ) u_radius (
        .aclk        (aclk),
        .en          (en),
        .radius_word (s_uniform_radius_word),
        .radius_out  (radius)
    );

    gnbm_angle #(
        .UNIFORM_BITS (UNIFORM_BITS)
    ) u_angle (
        .aclk       (aclk),
        .en         (en),
        .angle_word (s_uniform_angle_word),
        .cos_mag    (cos_mag),
        .cos_neg    (cos_neg)
    );

    // Delay the angle result to meet the longer radius path
    always_ff @(posedge aclk) begin
        if (en) begin
            dly_c_reg[0]   <= cos_mag;
            dly_neg_reg[0] <= cos_neg;
            for (int i = 1; i < ANG_DLY; i++) begin
                dly_c_reg[i]   <= dly_c_reg[i-1];
                dly_neg_reg[i] <= dly_neg_reg[i-1];
            end
        end
    end

    // Radius times cosine, Q58
    assign prod_full = 64'(radius) * 64'(dly_c_reg[ANG_DLY-1]);

    always_ff @(posedge aclk) begin
        if (en) begin
            prod_reg     <= prod_full[PROD_W-1:0];
            prod_neg_reg <= dly_neg_reg[ANG_DLY-1];
        end
    end

    // Round half up, saturate, apply sign
    always_comb begin
        sum = SUM_W'(prod_reg) + RND;
        mag = sum >> SHIFT;
        if (prod_neg_reg) begin
            sat = (mag > SAT_NEG) ? SAT_NEG : mag;
            sample_next = OUT_W'(SUM_W'(0) - sat);
        end else begin
            sat = (mag > SAT_POS) ? SAT_POS : mag;
            sample_next = OUT_W'(sat);
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            sample_reg <= sample_next;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_noise_sample = sample_reg;

    // A zero radius word never enters the valid line
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && zero_word) |=> !vld_reg[0])
        else $error("zero radius word entered the pipeline");

    // A stalled pipeline holds its valid bits
    assert property (@(posedge aclk) disable iff (!aresetn)
        !en |=> ($stable(vld_reg) && $stable(prod_vld_reg)))
        else $error("valid line moved during a stall");

    // A new output comes only from a valid product stage
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && !$past(m_valid_reg)) |-> $past(prod_vld_reg))
        else $error("output valid without a valid product");

endmodule

// File: bench/tb.sv
// Self-checking bench for gaussian_noise_box_muller: drives directed and random uniform word pairs
// through a valid/ready channel and checks every sample against a bit-exact model.
// Depends on gnbm_pkg and the gaussian_noise_box_muller RTL.
module tb;
    import gnbm_pkg::*;

    localparam int unsigned PIPE_LAT   = 64;
    localparam int unsigned N_RANDOM   = 1400;
    localparam longint unsigned CYCLE_LIMIT = 200000;

    typedef struct packed {
        logic [IN_W-1:0] radius;
        logic [IN_W-1:0] angle;
    } word_pair_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    logic [IN_W-1:0] s_uniform_radius_word = '0;
    logic [IN_W-1:0] s_uniform_angle_word = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    logic signed [OUT_W-1:0] m_noise_sample;

    word_pair_t pending_pairs[$];
    logic [OUT_W-1:0] expected_samples[$];
    int unsigned error_count = 0;
    longint unsigned cycle_count = 0;
    bit stimulus_done = 1'b0;
    int unsigned send_wait = 0;
    int unsigned recv_wait = 0;

    gaussian_noise_box_muller dut (.*);

    // Clock: period 4
    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    // Q28 log2 by repeated squaring of the Q31 mantissa
    function automatic longint unsigned log2_fixed(input longint unsigned v);
        int unsigned e;
        longint unsigned m, acc;
        e = 0;
        while (e < 31 && (v >> (e + 1)) != 0) e++;
        m = v << (31 - e);
        acc = longint'(e) << 28;
        for (int i = 1; i <= 28; i++) begin
            m = (m * m) >> 31;
            if (m >= (64'd1 << 32)) begin
                m = m >> 1;
                acc |= 64'd1 << (28 - i);
            end
        end
        return acc;
    endfunction

    function automatic longint unsigned root_floor(input longint unsigned a);
        longint unsigned res, bitv;
        res = 0;
        bitv = 64'd1 << 62;
        while (bitv > a) bitv >>= 2;
        while (bitv != 0) begin
            if (a >= res + bitv) begin
                a -= res + bitv;
                res = (res >> 1) + bitv;
            end else begin
                res >>= 1;
            end
            bitv >>= 2;
        end
        return res;
    endfunction

    function automatic longint unsigned qmul(input longint unsigned a, input longint unsigned b);
        return (a * b) >> 30;
    endfunction

    // Horner series for cos (sin_sel=0) or sin over [0, pi/4]
    function automatic longint unsigned trig_series(input longint unsigned x, input bit sin_sel);
        longint unsigned t, h, one;
        one = 64'd1 << 30;
        t = qmul(x, x);
        h = one - t / (sin_sel ? 72 : 56);
        h = one - qmul(t, h) / (sin_sel ? 42 : 30);
        h = one - qmul(t, h) / (sin_sel ? 20 : 12);
        h = one - qmul(t, h) / (sin_sel ? 6 : 2);
        return sin_sel ? qmul(x, h) : h;
    endfunction

    // Compute the expected sample; returns 0 when the pair yields none
    function automatic bit gaussian_sample(input word_pair_t p, output logic [OUT_W-1:0] y);
        longint unsigned mask, w1, w2, lmax, lw, d, r, s, phase, q, rq, m, c, mag, one;
        mask = 64'hFFFF_FFFF;
        one = 64'd1 << 30;
        w1 = p.radius;
        w2 = p.angle;
        y = '0;
        if (w1 == 0) return 1'b0;
        lmax = log2_fixed(mask);
        lw = log2_fixed(w1);
        d = (lmax > lw) ? lmax - lw : 0;
        r = (d * 64'd1488522236) >> 30;
        s = root_floor(r << 28);
        phase = ((w2 << 32) / mask) & mask;
        q = phase >> 30;
        rq = phase & (one - 1);
        m = q[0] ? one - rq : rq;
        if (m <= (one >> 1)) c = trig_series(qmul(m, 64'd1686629713), 1'b0);
        else c = trig_series(qmul(one - m, 64'd1686629713), 1'b1);
        mag = (s * c + (64'd1 << 45)) >> 46;
        if (q == 1 || q == 2) begin
            if (mag > 32768) mag = 32768;
            y = OUT_W'(17'h10000 - mag);
        end else begin
            if (mag > 32767) mag = 32767;
            y = OUT_W'(mag);
        end
        return 1'b1;
    endfunction

    function automatic logic [IN_W-1:0] rand_word();
        case ($urandom_range(0, 5))
            0: return 32'hFFFF_FFFF - $urandom_range(0, 3);
            1: return $urandom_range(0, 15);
            2: return 32'd1 << $urandom_range(0, 31);
            default: return $urandom;
        endcase
    endfunction

    // Fill the stimulus queue: directed corners first, then random pairs
    initial begin
        word_pair_t p;
        logic [IN_W-1:0] corners[6];
        corners = '{32'd0, 32'd1, 32'hFFFF_FFFF, 32'h8000_0000,
                    32'h4000_0000, 32'hC000_0000};
        foreach (corners[i]) begin
            p.radius = corners[i];
            p.angle = 32'h0;
            pending_pairs.push_back(p);
            p.radius = 32'd1;
            p.angle = corners[i];
            pending_pairs.push_back(p);
        end
        // sin branch, negative quadrants, saturation with tiny radius
        p = '{32'd1, 32'h6000_0000}; pending_pairs.push_back(p);
        p = '{32'd2, 32'h9000_0000}; pending_pairs.push_back(p);
        p = '{32'd0, 32'h1234_5678}; pending_pairs.push_back(p);
        p = '{32'h5555_5555, 32'hAAAA_AAAA}; pending_pairs.push_back(p);
        p = '{32'hAAAA_AAAA, 32'h5555_5555}; pending_pairs.push_back(p);
        for (int i = 0; i < N_RANDOM; i++) begin
            p.radius = rand_word();
            p.angle = rand_word();
            pending_pairs.push_back(p);
        end
    end

    // Driver: hold each transfer until accepted, random gaps between items
    always @(posedge aclk) begin
        word_pair_t p;
        logic [OUT_W-1:0] y;
        cycle_count <= cycle_count + 1;
        if (cycle_count == 6) aresetn <= 1'b1;
        if (aresetn) begin
            if (s_valid && s_ready) begin
                p = '{s_uniform_radius_word, s_uniform_angle_word};
                if (gaussian_sample(p, y)) expected_samples.push_back(y);
            end
            if (!s_valid || s_ready) begin
                if (send_wait != 0) begin
                    s_valid <= 1'b0;
                    send_wait <= send_wait - 1;
                end else if (pending_pairs.size() != 0) begin
                    p = pending_pairs.pop_front();
                    s_valid <= 1'b1;
                    s_uniform_radius_word <= p.radius;
                    s_uniform_angle_word <= p.angle;
                    send_wait <= ($urandom_range(0, 3) == 0) ? $urandom_range(0, 5) : 0;
                end else begin
                    s_valid <= 1'b0;
                    stimulus_done <= 1'b1;
                end
            end
        end
    end

    // Monitor: check each sample transfer, stall the result side at random
    always @(posedge aclk) begin
        logic [OUT_W-1:0] want;
        if (aresetn) begin
            if (m_valid && m_ready) begin
                if (expected_samples.size() == 0) begin
                    $error("unexpected sample: noise_sample actual %0d", m_noise_sample);
                    error_count++;
                end else begin
                    want = expected_samples.pop_front();
                    if (want !== m_noise_sample) begin
                        $error("noise_sample expected %0d actual %0d",
                               $signed(want), m_noise_sample);
                        error_count++;
                    end
                end
            end
            if (recv_wait != 0) begin
                m_ready <= 1'b0;
                recv_wait <= recv_wait - 1;
            end else begin
                m_ready <= 1'b1;
                recv_wait <= ($urandom_range(0, 3) == 0) ? $urandom_range(0, 5) : 0;
            end
        end
    end

    // End of run: drain, settle, then report
    initial begin
        wait (stimulus_done && expected_samples.size() == 0 || cycle_count > CYCLE_LIMIT);
        if (cycle_count <= CYCLE_LIMIT) begin
            repeat (PIPE_LAT + 16) @(posedge aclk);
        end
        if (cycle_count > CYCLE_LIMIT) begin
            $display("RESULT: ERROR");
        end else if (error_count == 0 && expected_samples.size() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end
endmodule
